[rtl/hcm_pkg.sv]
// Shared types, constants and mod-26 helper functions for the Hill cipher block.
package hcm_pkg;

    localparam int MOD_LETTERS = 26;
    localparam int UPPER_BASE  = 65;
    localparam int LOWER_BASE  = 97;

    // Offsets that make (byte - base) nonnegative before the reduction.
    localparam int LOWER_OFS = (LOWER_BASE / MOD_LETTERS + 1) * MOD_LETTERS - LOWER_BASE;
    localparam int UPPER_OFS = (UPPER_BASE / MOD_LETTERS + 1) * MOD_LETTERS - UPPER_BASE;

    localparam int KEY_W     = 45;
    localparam int CFG_IDX_W = 2;
    localparam int LET_W     = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEC   = 2'd2;

    // Operand codes for the adjugate sequence: key entries, one and zero.
    typedef logic [3:0] t_opnd;
    localparam t_opnd K00 = 4'd0;
    localparam t_opnd K01 = 4'd1;
    localparam t_opnd K02 = 4'd2;
    localparam t_opnd K10 = 4'd3;
    localparam t_opnd K11 = 4'd4;
    localparam t_opnd K12 = 4'd5;
    localparam t_opnd K20 = 4'd6;
    localparam t_opnd K21 = 4'd7;
    localparam t_opnd K22 = 4'd8;
    localparam t_opnd OPND_ONE  = 4'd9;
    localparam t_opnd OPND_ZERO = 4'd10;

    // One adjugate entry is a * b - c * d.
    typedef struct packed {
        t_opnd a;
        t_opnd b;
        t_opnd c;
        t_opnd d;
    } t_adj_ops;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic first;
    } t_mac_ctl;

    // Reduces a value below 1024 modulo 26 by folding: 32 is congruent to 6.
    function automatic logic [LET_W-1:0] fold26(input logic [9:0] v);
        logic [7:0] s1;
        logic [6:0] s2;
        logic [LET_W-1:0] res;
        s1 = 8'({v[9:5], 2'b00}) + 8'({v[9:5], 1'b0}) + 8'(v[4:0]);
        s2 = 7'({s1[7:5], 2'b00}) + 7'({s1[7:5], 1'b0}) + 7'(s1[4:0]);
        if (s2 >= 7'(2 * MOD_LETTERS)) begin
            res = 5'(s2 - 7'(2 * MOD_LETTERS));
        end else if (s2 >= 7'(MOD_LETTERS)) begin
            res = 5'(s2 - 7'(MOD_LETTERS));
        end else begin
            res = 5'(s2);
        end
        return res;
    endfunction

    // Key entries above 25 wrap once.
    function automatic logic [LET_W-1:0] key_red(input logic [LET_W-1:0] k);
        return (k >= 5'(MOD_LETTERS)) ? 5'(k - 5'(MOD_LETTERS)) : k;
    endfunction

    function automatic logic [LET_W-1:0] op_value(input t_opnd code,
                                                  input logic [KEY_W-1:0] key);
        logic [LET_W-1:0] res;
        case (code)
            OPND_ONE:  res = 5'd1;
            OPND_ZERO: res = 5'd0;
            default: begin
                res = (code <= K22) ? key_red(key[LET_W * int'(code) +: LET_W]) : 5'd0;
            end
        endcase
        return res;
    endfunction

    // Operands of adjugate entry e (row-major). The 3x3 entries are signed
    // cofactors written with cyclic indexes; the 2x2 form uses one and zero.
    function automatic t_adj_ops adj_ops(input logic n3, input logic [3:0] e);
        t_adj_ops ops;
        ops = '{a: OPND_ZERO, b: OPND_ZERO, c: OPND_ZERO, d: OPND_ZERO};
        if (n3) begin
            case (e)
                4'd0: ops = '{a: K11, b: K22, c: K12, d: K21};
                4'd1: ops = '{a: K21, b: K02, c: K22, d: K01};
                4'd2: ops = '{a: K01, b: K12, c: K02, d: K11};
                4'd3: ops = '{a: K12, b: K20, c: K10, d: K22};
                4'd4: ops = '{a: K22, b: K00, c: K20, d: K02};
                4'd5: ops = '{a: K02, b: K10, c: K00, d: K12};
                4'd6: ops = '{a: K10, b: K21, c: K11, d: K20};
                4'd7: ops = '{a: K20, b: K01, c: K21, d: K00};
                4'd8: ops = '{a: K00, b: K11, c: K01, d: K10};
                default: ops = '{a: OPND_ZERO, b: OPND_ZERO, c: OPND_ZERO, d: OPND_ZERO};
            endcase
        end else begin
            case (e)
                4'd0: ops = '{a: K11, b: OPND_ONE, c: OPND_ZERO, d: OPND_ZERO};
                4'd1: ops = '{a: OPND_ZERO, b: OPND_ZERO, c: K01, d: OPND_ONE};
                4'd3: ops = '{a: OPND_ZERO, b: OPND_ZERO, c: K10, d: OPND_ONE};
                4'd4: ops = '{a: K00, b: OPND_ONE, c: OPND_ZERO, d: OPND_ZERO};
                default: ops = '{a: OPND_ZERO, b: OPND_ZERO, c: OPND_ZERO, d: OPND_ZERO};
            endcase
        end
        return ops;
    endfunction

endpackage

[rtl/hcm_if.sv]
// Valid/ready channel interfaces for characters, results and configuration writes.
interface hcm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface hcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       block_end;
    logic       key_singular;
    modport source (output valid, output out_char, output block_end,
                    output key_singular, input ready);
    modport sink   (input valid, input out_char, input block_end,
                    input key_singular, output ready);
endinterface

interface hcm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hcm_pkg::CFG_IDX_W-1:0]  index;
    logic [hcm_pkg::KEY_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/hcm_mac26.sv]
// Shared mod-26 multiply-accumulate unit with a registered accumulator.
module hcm_mac26 (
    input  logic                      i_clk,
    input  hcm_pkg::t_mac_ctl         i_ctl,
    input  logic [hcm_pkg::LET_W-1:0] i_x,
    input  logic [hcm_pkg::LET_W-1:0] i_y,
    output logic [hcm_pkg::LET_W-1:0] o_acc
);
    import hcm_pkg::*;

    logic [LET_W-1:0] r_acc;
    logic [9:0]       w_sum;

    // Product of two values below 32 plus a reduced accumulator stays below 1024.
    assign w_sum = ({5'b0, i_x} * {5'b0, i_y}) + (i_ctl.first ? 10'd0 : {5'b0, r_acc});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= fold26(w_sum);
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/hill_cipher_mod26_block.sv]
// Hill cipher block over letters mod 26 with a 2x2 or 3x3 key.
//
//  Channel   Dir  Payload                                  Word accepted when
//  i_char    in   char_code[7:0]                           valid & ready
//  o_res     out  out_char[7:0], block_end, key_singular   valid & ready
//  i_cfg     in   index[1:0], data[44:0]                   valid & ready
//
// A character is taken while the sequencer is idle and no configuration
// write is offered. When a block of n characters is complete, each result
// row is accumulated on the shared multiply-accumulate unit and then loaded
// into the output register. The first decrypt block after a key or order
// write also builds the inverse key on the same unit: adjugate, determinant,
// inverse search and scaling, in that order. Reset is synchronous and active
// low; it clears the configuration to key zero, order 2, encrypt. A stalled
// output holds the sequencer in its load state while the input side stays
// closed.
module hill_cipher_mod26_block #(
    parameter int MAX_ORDER = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcm_in_if.sink    i_char,
    hcm_out_if.source o_res,
    hcm_cfg_if.sink   i_cfg
);
    import hcm_pkg::*;

    localparam int FILL_W = $clog2(MAX_ORDER);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADJ   = 3'd1;
    localparam logic [2:0] S_DET   = 3'd2;
    localparam logic [2:0] S_DLAT  = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_ROW   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Configuration.
    logic [KEY_W-1:0] r_key;
    logic [1:0]       r_order;
    logic             r_dec;

    // Letter buffer and derived decryption state.
    logic [LET_W-1:0]  r_buf [MAX_ORDER];
    logic [FILL_W-1:0] r_fill;
    logic [LET_W-1:0]  r_inv [9];
    logic [LET_W-1:0]  r_det;
    logic [LET_W-1:0]  r_det_inv;
    logic              r_inv_ready;
    logic              r_singular;

    // Sequencer.
    logic [2:0]       r_state;
    logic [3:0]       r_idx;
    logic [1:0]       r_phase;
    logic [LET_W-1:0] r_step;
    logic [1:0]       r_row;
    logic [1:0]       r_col;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_end;
    logic       r_out_sing;

    logic             w_n3;
    logic [1:0]       w_last;
    logic             w_in_acc;
    logic             w_cfg_acc;
    logic             w_out_free;
    logic [LET_W-1:0] w_letter;
    logic [3:0]       w_mat_idx;
    logic [3:0]       w_det_idx;
    logic [3:0]       w_rd_idx;
    logic [LET_W-1:0] w_inv_rd;
    t_adj_ops         w_ops;
    t_mac_ctl         w_mac_ctl;
    logic [LET_W-1:0] w_mac_x;
    logic [LET_W-1:0] w_mac_y;
    logic [LET_W-1:0] w_acc;
    logic [7:0]       w_base_out;

    assign w_n3   = (r_order == 2'd3) && (MAX_ORDER >= 3);
    assign w_last = w_n3 ? 2'd2 : 2'd1;

    // A configuration write takes precedence over a character in the same cycle,
    // so the character always sees the new settings.
    assign i_char.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready  = (r_state == S_IDLE);
    assign w_in_acc     = i_char.valid && i_char.ready;
    assign w_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;

    // Letter value of the incoming byte, relative to the case that is read.
    assign w_letter = fold26({2'b00, i_char.char_code}
                             + (r_dec ? 10'(UPPER_OFS) : 10'(LOWER_OFS)));

    // Row-major position of the current matrix element and of column zero
    // of the adjugate row used for the determinant.
    assign w_mat_idx = ({2'b00, r_row} << 1) + {2'b00, r_row} + {2'b00, r_col};
    assign w_det_idx = ({2'b00, r_col} << 1) + {2'b00, r_col};

    // The inverse key store has a single read address.
    always_comb begin
        case (r_state)
            S_DET:   w_rd_idx = w_det_idx;
            S_ROW:   w_rd_idx = w_mat_idx;
            default: w_rd_idx = r_idx;
        endcase
    end
    assign w_inv_rd = r_inv[w_rd_idx];

    assign w_ops      = adj_ops(w_n3, r_idx);
    assign w_base_out = r_dec ? 8'(LOWER_BASE) : 8'(UPPER_BASE);

    // Operand selection for the shared unit.
    always_comb begin
        w_mac_ctl = '{en: 1'b0, first: 1'b0};
        w_mac_x   = '0;
        w_mac_y   = '0;
        case (r_state)
            S_ADJ: begin
                if (r_phase == 2'd0) begin
                    w_mac_ctl = '{en: 1'b1, first: 1'b1};
                    w_mac_x   = op_value(w_ops.a, r_key);
                    w_mac_y   = op_value(w_ops.b, r_key);
                end else if (r_phase == 2'd1) begin
                    // Subtracting c*d is adding c*(26-d).
                    w_mac_ctl = '{en: 1'b1, first: 1'b0};
                    w_mac_x   = op_value(w_ops.c, r_key);
                    w_mac_y   = 5'(MOD_LETTERS) - op_value(w_ops.d, r_key);
                end
            end
            S_DET: begin
                w_mac_ctl = '{en: 1'b1, first: (r_col == 2'd0)};
                w_mac_x   = op_value(t_opnd'(r_col), r_key);
                w_mac_y   = w_inv_rd;
            end
            S_SRCH: begin
                w_mac_ctl = '{en: (r_phase == 2'd0), first: 1'b1};
                w_mac_x   = r_det;
                w_mac_y   = r_step;
            end
            S_SCALE: begin
                w_mac_ctl = '{en: (r_phase == 2'd0), first: 1'b1};
                w_mac_x   = w_inv_rd;
                w_mac_y   = r_det_inv;
            end
            S_ROW: begin
                w_mac_ctl = '{en: 1'b1, first: (r_col == 2'd0)};
                w_mac_x   = r_dec ? w_inv_rd : op_value(t_opnd'(w_mat_idx), r_key);
                w_mac_y   = r_buf[r_col[FILL_W-1:0]];
            end
            default: begin
                w_mac_ctl = '{en: 1'b0, first: 1'b0};
            end
        endcase
    end

    hcm_mac26 u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_x   (w_mac_x),
        .i_y   (w_mac_y),
        .o_acc (w_acc)
    );

    // Inverse key store and output payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADJ && r_phase == 2'd2) begin
            r_inv[r_idx] <= w_acc;
        end else if (r_state == S_SCALE && r_phase == 2'd1) begin
            r_inv[r_idx] <= w_acc;
        end
        if (r_state == S_DLAT) begin
            r_det <= w_acc;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_char <= w_base_out + {3'b000, w_acc};
            r_out_end  <= (r_row == w_last);
            r_out_sing <= r_dec && r_singular;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_order     <= 2'd2;
            r_dec       <= 1'b0;
            r_fill      <= '0;
            r_det_inv   <= '0;
            r_inv_ready <= 1'b0;
            r_singular  <= 1'b0;
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_buf[i] <= '0;
            end
        end else begin
            // A new word is loaded when the register is free; otherwise a taken
            // word empties it.
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_buf[r_fill] <= w_letter;
                        if (2'(r_fill) == w_last) begin
                            r_fill  <= '0;
                            r_idx   <= '0;
                            r_phase <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= (r_dec && !r_inv_ready) ? S_ADJ : S_ROW;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                S_ADJ: begin
                    if (r_phase == 2'd2) begin
                        r_phase <= '0;
                        if (r_idx == 4'd8) begin
                            r_col   <= '0;
                            r_state <= S_DET;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end else begin
                        r_phase <= r_phase + 2'd1;
                    end
                end
                S_DET: begin
                    // Expansion along the first key row.
                    if (r_col == 2'd2) begin
                        r_state <= S_DLAT;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_DLAT: begin
                    r_step  <= 5'd1;
                    r_phase <= '0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= 2'd1;
                    end else begin
                        r_phase <= '0;
                        if (w_acc == 5'd1) begin
                            r_det_inv  <= r_step;
                            r_singular <= 1'b0;
                            r_idx      <= '0;
                            r_state    <= S_SCALE;
                        end else if (r_step == 5'(MOD_LETTERS - 1)) begin
                            // No inverse exists: scale by minus one.
                            r_det_inv  <= 5'(MOD_LETTERS - 1);
                            r_singular <= 1'b1;
                            r_idx      <= '0;
                            r_state    <= S_SCALE;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                S_SCALE: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= 2'd1;
                    end else begin
                        r_phase <= '0;
                        if (r_idx == 4'd8) begin
                            r_inv_ready <= 1'b1;
                            r_row       <= '0;
                            r_col       <= '0;
                            r_state     <= S_ROW;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                S_ROW: begin
                    if (r_col == w_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (r_row == w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_col   <= '0;
                            r_state <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration writes land only while idle.
            if (w_cfg_acc) begin
                case (i_cfg.index)
                    REG_KEY: begin
                        r_key       <= i_cfg.data;
                        r_inv_ready <= 1'b0;
                    end
                    REG_ORDER: begin
                        r_order     <= i_cfg.data[1:0];
                        r_inv_ready <= 1'b0;
                        r_fill      <= '0;
                    end
                    REG_DEC: begin
                        r_dec <= i_cfg.data[0];
                    end
                    default: begin
                        r_dec <= r_dec;
                    end
                endcase
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_char     = r_out_char;
    assign o_res.block_end    = r_out_end;
    assign o_res.key_singular = r_out_sing;

    // The partial block never reaches the block size of the current order.
    a_fill_below_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        2'(r_fill) <= w_last)
        else $error("letter fill count reached the block size");

    // A decrypt row is only computed once the inverse key is built.
    a_dec_needs_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW && r_dec) |-> r_inv_ready)
        else $error("decrypt row started with a stale inverse key");

    // A nonsingular inverse key really holds the determinant inverse.
    a_det_inverse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inv_ready && !r_singular) |-> (fold26(10'(r_det) * 10'(r_det_inv)) == 5'd1))
        else $error("determinant inverse does not invert the determinant");

    // The inverse search only leaves with the singular flag when no step hit one.
    a_search_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && r_phase == 2'd1 && w_acc != 5'd1
         && r_step != 5'(MOD_LETTERS - 1)) |=> (r_state == S_SRCH))
        else $error("inverse search ended early");

endmodule
